>>> src/dual_echo_pulse_ranger_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual echo pulse ranger
// Clocked assertion forms used by the checker file.
// ----------------------------------------------------------------------------
`ifndef DUAL_ECHO_PULSE_RANGER_MACROS_SVH
`define DUAL_ECHO_PULSE_RANGER_MACROS_SVH

// checked on every rising edge, masked while reset is asserted
`define DEPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every rising edge, reset included
`define DEPR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/depr_pkg.sv
// ----------------------------------------------------------------------------
// Dual echo pulse ranger package
// Command codes, field widths and distance constants.
// ----------------------------------------------------------------------------
package depr_pkg;

  // field widths
  localparam int unsigned TimeW = 16;
  localparam int unsigned DistW = 10;

  // command codes
  localparam logic [1:0] CMD_CAPTURE   = 2'd0;
  localparam logic [1:0] CMD_WATCHDOG  = 2'd1;
  localparam logic [1:0] CMD_TRIG_BEG  = 2'd2;
  localparam logic [1:0] CMD_TRIG_END  = 2'd3;

  // distance reported for no echo or out of range
  localparam logic [DistW-1:0] DIST_NONE = 10'd999;

  // widths above this limit are out of range
  localparam logic [17:0] WIDTH_LIMIT = 18'd19000;

  // reset value of the timer period register
  localparam logic [TimeW-1:0] PERIOD_RESET = 16'hFFFF;

  // reciprocal of 583 scaled by 2^28, rounded up; exact for dividends below 2^18
  localparam int unsigned RecipShift = 28;
  localparam logic [18:0] RECIP_583  = 19'd460439;

endpackage

>>> src/dual_echo_pulse_ranger.sv
// ----------------------------------------------------------------------------
// Dual echo pulse ranger
// Two-channel ultrasonic echo ranger with alternating trigger lines.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one event per request:
//   cmd_i selects capture edge, watchdog tick, trigger start or trigger end;
//   channel_i and capture_value_i matter for a capture edge only.
//   Output channel (out_valid_o / out_stall_i) returns one result per event:
//   both distances in cm (999 for none), trigger levels, armed flags and
//   measure_done, all showing the state after that event.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes the timer period
//   used for wrap correction; write it only while the block is idle.
// Timing:
//   An accepted event is held in the input register and then evaluated into
//   the result register, which presents its result. One event per cycle is
//   sustained while out_stall_i is low; the evaluation of an event
//   is a single pass of the width, range check and reciprocal multiply.
// Reset and stall:
//   Reset clears all channel state, both stores, trigger lines and the
//   alternation, and sets the timer period to 65535. While out_stall_i holds
//   a result, the input register keeps one event and then stalls the input.
// ----------------------------------------------------------------------------
module dual_echo_pulse_ranger (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [depr_pkg::TimeW-1:0]  cfg_data_i,
  // event requests
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  cmd_i,
  input  logic                        channel_i,
  input  logic [depr_pkg::TimeW-1:0]  capture_value_i,
  // results
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [depr_pkg::DistW-1:0]  left_distance_o,
  output logic [depr_pkg::DistW-1:0]  right_distance_o,
  output logic                        left_trigger_o,
  output logic                        right_trigger_o,
  output logic                        left_wait_falling_o,
  output logic                        right_wait_falling_o,
  output logic                        measure_done_o
);

  // input register
  logic                       s1_valid_q;
  logic [1:0]                 s1_cmd_q;
  logic                       s1_chan_q;
  logic [depr_pkg::TimeW-1:0] s1_cap_q;

  // channel state
  logic [depr_pkg::TimeW-1:0] period_q;
  logic                       left_armed_q, left_armed_d;
  logic                       right_armed_q, right_armed_d;
  logic [depr_pkg::TimeW-1:0] left_start_q, left_start_d;
  logic [depr_pkg::TimeW-1:0] right_start_q, right_start_d;
  logic [depr_pkg::DistW-1:0] left_dist_q, left_dist_d;
  logic [depr_pkg::DistW-1:0] right_dist_q, right_dist_d;
  logic                       next_right_q, next_right_d;
  logic                       trig_left_q, trig_left_d;
  logic                       trig_right_q, trig_right_d;
  logic                       done_d;

  // result register
  logic                       res_valid_q;
  logic [depr_pkg::DistW-1:0] res_left_dist_q;
  logic [depr_pkg::DistW-1:0] res_right_dist_q;
  logic                       res_trig_left_q;
  logic                       res_trig_right_q;
  logic                       res_left_wait_q;
  logic                       res_right_wait_q;
  logic                       res_done_q;

  logic                       advance;
  logic                       accept;
  logic [depr_pkg::TimeW-1:0] sel_start;
  logic [depr_pkg::DistW-1:0] meas_dist;

  // handshake
  assign advance     = s1_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !advance;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // timer period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= depr_pkg::PERIOD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      period_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q  <= cmd_i;
      s1_chan_q <= channel_i;
      s1_cap_q  <= capture_value_i;
    end
  end

  // width to distance for the addressed channel
  assign sel_start = s1_chan_q ? right_start_q : left_start_q;

  depr_calc u_calc (
    .period_i (period_q),
    .start_i  (sel_start),
    .stop_i   (s1_cap_q),
    .dist_o   (meas_dist)
  );

  // event decode and next state
  always_comb begin
    left_armed_d  = left_armed_q;
    right_armed_d = right_armed_q;
    left_start_d  = left_start_q;
    right_start_d = right_start_q;
    left_dist_d   = left_dist_q;
    right_dist_d  = right_dist_q;
    next_right_d  = next_right_q;
    trig_left_d   = trig_left_q;
    trig_right_d  = trig_right_q;
    done_d        = 1'b0;
    unique case (s1_cmd_q)
      depr_pkg::CMD_CAPTURE: begin
        if (!s1_chan_q) begin
          if (!left_armed_q) begin
            left_start_d = s1_cap_q;
            left_armed_d = 1'b1;
          end else begin
            left_dist_d  = meas_dist;
            left_armed_d = 1'b0;
            done_d       = 1'b1;
          end
        end else begin
          if (!right_armed_q) begin
            right_start_d = s1_cap_q;
            right_armed_d = 1'b1;
          end else begin
            right_dist_d  = meas_dist;
            right_armed_d = 1'b0;
            done_d        = 1'b1;
          end
        end
      end
      depr_pkg::CMD_WATCHDOG: begin
        if (left_armed_q) begin
          left_armed_d = 1'b0;
          left_start_d = '0;
          left_dist_d  = depr_pkg::DIST_NONE;
        end
        if (right_armed_q) begin
          right_armed_d = 1'b0;
          right_start_d = '0;
          right_dist_d  = depr_pkg::DIST_NONE;
        end
      end
      depr_pkg::CMD_TRIG_BEG: begin
        if (!next_right_q) begin
          trig_left_d = 1'b1;
        end else begin
          trig_right_d = 1'b1;
        end
        next_right_d = !next_right_q;
      end
      depr_pkg::CMD_TRIG_END: begin
        trig_left_d  = 1'b0;
        trig_right_d = 1'b0;
      end
      default: begin
        trig_left_d  = trig_left_q;
      end
    endcase
  end

  // channel state update as an event leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_armed_q  <= 1'b0;
      right_armed_q <= 1'b0;
      left_start_q  <= '0;
      right_start_q <= '0;
      left_dist_q   <= '0;
      right_dist_q  <= '0;
      next_right_q  <= 1'b0;
      trig_left_q   <= 1'b0;
      trig_right_q  <= 1'b0;
    end else if (advance) begin
      left_armed_q  <= left_armed_d;
      right_armed_q <= right_armed_d;
      left_start_q  <= left_start_d;
      right_start_q <= right_start_d;
      left_dist_q   <= left_dist_d;
      right_dist_q  <= right_dist_d;
      next_right_q  <= next_right_d;
      trig_left_q   <= trig_left_d;
      trig_right_q  <= trig_right_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  // result payload, a stored zero distance reads as none
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_left_dist_q  <= (left_dist_d == '0) ? depr_pkg::DIST_NONE : left_dist_d;
      res_right_dist_q <= (right_dist_d == '0) ? depr_pkg::DIST_NONE : right_dist_d;
      res_trig_left_q  <= trig_left_d;
      res_trig_right_q <= trig_right_d;
      res_left_wait_q  <= left_armed_d;
      res_right_wait_q <= right_armed_d;
      res_done_q       <= done_d;
    end
  end

  assign out_valid_o          = res_valid_q;
  assign left_distance_o      = res_left_dist_q;
  assign right_distance_o     = res_right_dist_q;
  assign left_trigger_o       = res_trig_left_q;
  assign right_trigger_o      = res_trig_right_q;
  assign left_wait_falling_o  = res_left_wait_q;
  assign right_wait_falling_o = res_right_wait_q;
  assign measure_done_o       = res_done_q;

endmodule

>>> src/depr_calc.sv
// ----------------------------------------------------------------------------
// Echo width to distance
// Wrap-corrected pulse width, range check and width*10/583 in cm.
// ----------------------------------------------------------------------------
module depr_calc (
  input  logic [depr_pkg::TimeW-1:0] period_i,
  input  logic [depr_pkg::TimeW-1:0] start_i,
  input  logic [depr_pkg::TimeW-1:0] stop_i,
  output logic [depr_pkg::DistW-1:0] dist_o
);

  logic signed [17:0] width;
  logic               out_of_range;
  logic [17:0]        scaled;
  logic [36:0]        product;
  logic [8:0]         quot;

  // pulse width, with one wrap of the timer when the end precedes the start
  always_comb begin
    if (stop_i >= start_i) begin
      width = $signed({2'b00, stop_i}) - $signed({2'b00, start_i});
    end else begin
      width = $signed({2'b00, period_i}) + $signed({2'b00, stop_i}) + 18'sd1
              - $signed({2'b00, start_i});
    end
  end

  // negative width only comes from a start above the period
  assign out_of_range = width[17] || ($unsigned(width) > depr_pkg::WIDTH_LIMIT);

  // width * 10 as shift-add, at most 190000
  assign scaled  = {width[14:0], 3'b000} + {2'b00, width[14:0], 1'b0};

  // divide by 583 through the reciprocal
  assign product = {19'd0, scaled} * {18'd0, depr_pkg::RECIP_583};
  assign quot    = product[depr_pkg::RecipShift +: 9];

  assign dist_o  = out_of_range ? depr_pkg::DIST_NONE : {1'b0, quot};

endmodule

>>> src/depr_checker.sv
// ----------------------------------------------------------------------------
// Dual echo pulse ranger checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "dual_echo_pulse_ranger_macros.svh"

module depr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [depr_pkg::DistW-1:0] left_distance_o,
  input logic [depr_pkg::DistW-1:0] right_distance_o,
  input logic                       left_wait_falling_o,
  input logic                       right_wait_falling_o,
  input logic                       measure_done_o
);

  logic                         out_stalled;
  logic [2*depr_pkg::DistW:0]   res_payload;
  logic                         dist_ok;
  logic                         meas_out;
  logic                         both_armed;

  // result terms watched by the assertions
  assign out_stalled = out_valid_o && out_stall_i;
  assign res_payload = {left_distance_o, right_distance_o, measure_done_o};
  assign meas_out    = out_valid_o && measure_done_o;
  assign both_armed  = left_wait_falling_o && right_wait_falling_o;

  // both distances inside 1..999
  assign dist_ok = (left_distance_o != '0) && (right_distance_o != '0) &&
                   (left_distance_o <= depr_pkg::DIST_NONE) &&
                   (right_distance_o <= depr_pkg::DIST_NONE);

  // a stalled result stays and keeps its payload
  `DEPR_ASSERT(a_out_hold, out_stalled |=> out_valid_o && $stable(res_payload), "result not held")

  // reported distances are in 1..999
  `DEPR_ASSERT(a_dist_range, out_valid_o |-> dist_ok, "distance out of range")

  // a finished measurement never leaves both channels armed
  `DEPR_ASSERT(a_done_disarm, meas_out |-> !both_armed, "measurement left both channels armed")

  // nothing pending in the cycle after a reset edge
  `DEPR_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o && !in_stall_o, "active in reset")

endmodule

bind dual_echo_pulse_ranger depr_checker u_depr_checker (.*);
